// File: rtl/core/pal_pkg.sv
// pal_pkg: shared types and constants for the positional array list
// request mode codes, sequencer states and the result bundle
// no dependencies
`timescale 1ns / 1ps

package pal_pkg;

    // fixed field widths
    localparam int DATA_W      = 32;
    localparam int POS_W       = 12;
    localparam int COUNT_OUT_W = 7;

    // default list capacity
    localparam int CAPACITY_DEF = 64;

    // request modes
    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RD_WAIT = 2'd1,
        ST_SHIFT   = 2'd2,
        ST_DONE    = 2'd3
    } state_t;

    // one result transaction
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]   count;
        logic                     is_empty;
        logic                     is_full;
    } res_t;

endpackage

// File: rtl/core/pal_ram.sv
// pal_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
`timescale 1ns / 1ps

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/pal_seq.sv
// pal_seq: request sequencer for the positional array list
// checks positions, drives the element ram and moves one element per cycle
// depends on pal_pkg
`timescale 1ns / 1ps

module pal_seq import pal_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request side
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_mode,
    input  logic [POS_W-1:0]  in_position,
    input  logic [DATA_W-1:0] in_value,
    // result side
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    // element ram
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [DATA_W-1:0] ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  logic [DATA_W-1:0] ram_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = POS_W + 1;
    localparam int EW = CW + COUNT_OUT_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pend_reg, pend_next;
    mode_t             mode_reg, mode_next;
    logic [AW-1:0]     pos_m1_reg, pos_m1_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              ok_reg, ok_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [CW-1:0]     moves_reg, moves_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;

    logic [POS_W-1:0]  pos_m1_full;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     ins_moves_x;
    logic [XW-1:0]     rem_moves_x;
    logic              in_range;
    logic              ins_range;
    logic              is_insert;
    mode_t             req_mode;
    logic [EW-1:0]     cnt_ext;

    // position checks against the current count
    assign pos_m1_full = in_position - POS_W'(1);
    assign pos_x       = XW'(in_position);
    assign cnt_x       = XW'(count_reg);
    assign ins_moves_x = cnt_x - pos_x + XW'(1);
    assign rem_moves_x = cnt_x - pos_x;
    assign in_range    = (in_position != '0) && (pos_x <= cnt_x);
    assign ins_range   = (count_reg != CW'(CAPACITY)) && (in_position != '0)
                         && (pos_x <= cnt_x + XW'(1));
    assign req_mode    = mode_t'(in_mode);
    assign is_insert   = (mode_reg == MODE_INSERT);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // request payload and shift pointers
    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        pos_m1_reg    <= pos_m1_next;
        val_reg       <= val_next;
        ok_reg        <= ok_next;
        rd_reg        <= rd_next;
        moves_reg     <= moves_next;
        rd_idx_reg    <= rd_idx_next;
        pend_addr_reg <= pend_addr_next;
    end

    // next state, ram access and handshakes
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        mode_next      = mode_reg;
        pos_m1_next    = pos_m1_reg;
        val_next       = val_reg;
        ok_next        = ok_reg;
        rd_next        = rd_reg;
        moves_next     = moves_reg;
        rd_idx_next    = rd_idx_reg;
        pend_addr_next = pend_addr_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = rd_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                ram_raddr = pos_m1_full[AW-1:0];
                if (in_valid) begin
                    mode_next   = req_mode;
                    pos_m1_next = pos_m1_full[AW-1:0];
                    val_next    = in_value;
                    rd_next     = '0;
                    pend_next   = 1'b0;
                    case (req_mode)
                        MODE_READ: begin
                            ok_next    = in_range;
                            state_next = in_range ? ST_RD_WAIT : ST_DONE;
                        end
                        MODE_WRITE: begin
                            ok_next    = in_range;
                            ram_we     = in_range;
                            ram_waddr  = pos_m1_full[AW-1:0];
                            ram_wdata  = in_value;
                            state_next = ST_DONE;
                        end
                        MODE_INSERT: begin
                            // move entries count-1 down to pos-1 up one place
                            ok_next     = ins_range;
                            moves_next  = ins_moves_x[CW-1:0];
                            rd_idx_next = AW'(count_reg - CW'(1));
                            state_next  = ins_range ? ST_SHIFT : ST_DONE;
                        end
                        default: begin
                            // move entries pos up to count-1 down one place
                            ok_next     = in_range;
                            moves_next  = rem_moves_x[CW-1:0];
                            rd_idx_next = pos_x[AW-1:0];
                            state_next  = in_range ? ST_SHIFT : ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                rd_next    = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SHIFT: begin
                // write back the element read in the previous cycle
                ram_we = pend_reg;
                if (moves_reg != '0) begin
                    rd_idx_next    = is_insert ? rd_idx_reg - AW'(1) : rd_idx_reg + AW'(1);
                    pend_addr_next = is_insert ? rd_idx_reg + AW'(1) : rd_idx_reg - AW'(1);
                    moves_next     = moves_reg - CW'(1);
                    pend_next      = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                // shift drained: place the new element and update the count
                if (moves_reg == '0 && !pend_reg) begin
                    if (is_insert) begin
                        ram_we     = 1'b1;
                        ram_waddr  = pos_m1_reg;
                        ram_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result bundle, count reported in its low bits
    assign cnt_ext        = EW'(count_reg);
    assign res.ok         = ok_reg;
    assign res.read_value = rd_reg;
    assign res.count      = cnt_ext[COUNT_OUT_W-1:0];
    assign res.is_empty   = (count_reg == '0);
    assign res.is_full    = (count_reg == CW'(CAPACITY));

endmodule

// File: rtl/core/positional_array_list.sv
// Positional array list: an ordered list of up to CAPACITY signed 32-bit
// values addressed by 1-based position, held in one synchronous ram. Each
// transaction reads, overwrites, inserts before or removes at a position and
// returns one result with ok, read value, count and empty/full flags. A
// request is taken only when the sequencer is idle; a finished result waits
// in an output register, so the next request can be taken while it is
// pending. An overwrite or a rejected request goes straight to the result,
// a read waits for the registered ram data, and remove and insert first
// shift the elements from the position to the end of the list, one
// element per cycle through the single write port of the element ram. Reset
// empties the list; the ram needs no clearing pass.
//
// top level: instantiates pal_seq and pal_ram, holds the output register
// depends on pal_pkg
`timescale 1ns / 1ps

module positional_array_list import pal_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [COUNT_OUT_W-1:0]   m_count,
    output logic                     m_is_empty,
    output logic                     m_is_full
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              m_valid_reg, m_valid_next;
    res_t              out_reg;

    pal_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_mode     (s_mode),
        .in_position (s_position),
        .in_value    (s_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    pal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = out_reg.ok;
    assign m_read_value = out_reg.read_value;
    assign m_count      = out_reg.count;
    assign m_is_empty   = out_reg.is_empty;
    assign m_is_full    = out_reg.is_full;

endmodule

// File: rtl/core/pal_checker.sv
// pal_checker: port-level assertions for positional_array_list
// attached to the top level by the bind below; depends on pal_pkg
`timescale 1ns / 1ps

module pal_checker import pal_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_ok,
    input logic signed [DATA_W-1:0] m_read_value,
    input logic [COUNT_OUT_W-1:0]   m_count,
    input logic                     m_is_empty,
    input logic                     m_is_full
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_read_value)
            && $stable(m_count) && $stable(m_is_empty) && $stable(m_is_full))
        else $error("result changed while stalled");

    // a rejected request never returns data
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_read_value == '0)
        else $error("rejected request returned data");

    // an empty list reports a zero count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_count == '0)
        else $error("empty flag with nonzero count");

    // empty and full are exclusive
    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_empty && m_is_full))
        else $error("list reported both empty and full");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_ok         (m_ok),
    .m_read_value (m_read_value),
    .m_count      (m_count),
    .m_is_empty   (m_is_empty),
    .m_is_full    (m_is_full)
);
